// ===== rtl/hmrgb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmrgb_pkg
// types and codes shared by the rgb histogram matching block
// ----------------------------------------------------------------------------
package hmrgb_pkg;

  // item function codes
  localparam logic [2:0] FUNC_LOAD_SRC = 3'd0;
  localparam logic [2:0] FUNC_LOAD_REF = 3'd1;
  localparam logic [2:0] FUNC_BUILD    = 3'd2;
  localparam logic [2:0] FUNC_MAP      = 3'd3;
  localparam logic [2:0] FUNC_CLEAR    = 3'd4;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BUILD = 1'b1;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       count_saturated;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/histogram_matching_rgb.sv =====
// load item: read, then write, each active channel's histogram count in turn
// map item: read each active channel's table entry in turn, then push the result word
// build item: per channel a prefix pass over all levels, then for each level the single
// nearest-count compare unit steps over every reference level; a clear sweeps a row a cycle
// one item at a time; no item is taken while an item is at work or the clear runs
// reset clears control, then sweeps histograms and map table to zero
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_matching_rgb
// per-channel histogram matching of rgb pixels with a shared search unit
// ----------------------------------------------------------------------------
module histogram_matching_rgb #(
  parameter int MAX_PIXELS = 1048576,
  parameter int CHANNELS   = 3,
  parameter int LEVELS     = 256
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire hmrgb_pkg::in_word_t  in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output hmrgb_pkg::out_word_t      out_data_o,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire                       cfg_data_i
);

  // only three color channels exist
  localparam int NCH   = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int LW    = $clog2(LEVELS);
  localparam int AW    = CHW + LW;
  localparam int DEPTH = NCH * (2 ** LW);
  localparam int CW    = $clog2(MAX_PIXELS + 1);
  localparam int CUMW  = CW + LW;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_LD_RD  = 4'd2;
  localparam logic [3:0] S_LD_WR  = 4'd3;
  localparam logic [3:0] S_MP_RD  = 4'd4;
  localparam logic [3:0] S_MP_WR  = 4'd5;
  localparam logic [3:0] S_PF_RD  = 4'd6;
  localparam logic [3:0] S_PF_AC  = 4'd7;
  localparam logic [3:0] S_SI_RD  = 4'd8;
  localparam logic [3:0] S_SI_LD  = 4'd9;
  localparam logic [3:0] S_SJ_RD  = 4'd10;
  localparam logic [3:0] S_SJ_CMP = 4'd11;
  localparam logic [3:0] S_PUSH   = 4'd12;

  localparam logic [LW-1:0]  LVL_LAST = LW'(LEVELS - 1);
  localparam logic [CHW-1:0] CH_LAST  = CHW'(NCH - 1);
  localparam logic [AW-1:0]  CLR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0]  CNT_MAX  = CW'(MAX_PIXELS);

  // control state
  logic [3:0]     state_q, state_d;
  logic [CHW-1:0] ch_q, ch_d;
  logic [LW-1:0]  i_q, i_d;
  logic [LW-1:0]  j_q, j_d;
  logic [AW-1:0]  clr_addr_q, clr_addr_d;
  logic           clr_map_q, clr_map_d;
  logic           sat_q, sat_d;
  logic           inv_q;
  logic           out_valid_q, out_valid_d;

  // payload state
  logic [2:0]      func_q, func_d;
  logic [LW-1:0]   lvl_q [NCH];
  logic [LW-1:0]   lvl_d [NCH];
  logic [LW-1:0]   res_q [NCH];
  logic [LW-1:0]   res_d [NCH];
  logic            kind_q, kind_d;
  logic [CUMW-1:0] acc_s_q, acc_s_d, acc_r_q, acc_r_d;
  logic [CUMW-1:0] s_q, s_d, best_q, best_d;
  logic [LW-1:0]   win_q, win_d;
  hmrgb_pkg::out_word_t out_q, out_d;

  // memories: histograms and map table per {channel, level}, cumulative per level
  logic [CW-1:0]   src_mem [DEPTH];
  logic [CW-1:0]   ref_mem [DEPTH];
  logic [LW-1:0]   map_mem [DEPTH];
  logic [CUMW-1:0] sc_mem  [2 ** LW];
  logic [CUMW-1:0] rc_mem  [2 ** LW];

  logic [AW-1:0]   hist_ra, hist_wa, map_ra, map_wa;
  logic            src_we, ref_we, map_we, cum_we;
  logic [CW-1:0]   src_wd, ref_wd, src_rd_q, ref_rd_q;
  logic [LW-1:0]   map_wd, map_rd_q;
  logic [LW-1:0]   sc_ra, rc_ra;
  logic [CUMW-1:0] sc_rd_q, rc_rd_q;

  // combinational helpers
  logic [7:0]      px_in [NCH];
  logic [LW-1:0]   lvl_cur;
  logic [CW-1:0]   hist_cur;
  logic [CUMW-1:0] diff;
  logic            take;
  logic            can_push;
  logic            accept;

  // clamp to the top level; the caller applies the optional inversion
  function automatic logic [LW-1:0] clamp_level(input logic [7:0] v);
    logic [LW-1:0] r;
    if ({1'b0, v} >= 9'(LEVELS)) begin
      r = LVL_LAST;
    end else begin
      r = LW'(v);
    end
    return r;
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign can_push    = !out_valid_q || !out_stall_i;

  always_comb begin
    px_in[0] = in_data_i.red;
    if (NCH > 1) px_in[NCH > 1 ? 1 : 0] = in_data_i.green;
    if (NCH > 2) px_in[NCH > 2 ? 2 : 0] = in_data_i.blue;
  end

  assign lvl_cur  = lvl_q[ch_q];
  assign hist_cur = (func_q == hmrgb_pkg::FUNC_LOAD_SRC) ? src_rd_q : ref_rd_q;

  // shared compare unit: distance of reference count to source count
  assign diff = (rc_rd_q >= s_q) ? (rc_rd_q - s_q) : (s_q - rc_rd_q);
  assign take = (j_q == '0) || (diff <= best_q);

  // memory address and write control
  always_comb begin
    hist_ra = {ch_q, j_q};
    hist_wa = {ch_q, lvl_cur};
    src_we  = 1'b0;
    ref_we  = 1'b0;
    src_wd  = '0;
    ref_wd  = '0;
    map_ra  = {ch_q, lvl_cur};
    map_wa  = {ch_q, i_q};
    map_we  = 1'b0;
    map_wd  = '0;
    sc_ra   = (state_q == S_SI_RD) ? i_q : j_q;
    rc_ra   = j_q;
    cum_we  = 1'b0;
    case (state_q)
      S_CLR: begin
        hist_wa = clr_addr_q;
        map_wa  = clr_addr_q;
        src_we  = 1'b1;
        ref_we  = 1'b1;
        map_we  = clr_map_q;
      end
      S_LD_RD: begin
        hist_ra = {ch_q, lvl_cur};
      end
      S_LD_WR: begin
        src_we = (func_q == hmrgb_pkg::FUNC_LOAD_SRC);
        ref_we = (func_q == hmrgb_pkg::FUNC_LOAD_REF);
        src_wd = (hist_cur >= CNT_MAX) ? CNT_MAX : hist_cur + 1'b1;
        ref_wd = src_wd;
      end
      S_PF_AC: begin
        cum_we = 1'b1;
      end
      S_SJ_CMP: begin
        map_we = (j_q == LVL_LAST);
        map_wd = take ? j_q : win_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[hist_wa] <= src_wd;
    src_rd_q <= src_mem[hist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[hist_wa] <= ref_wd;
    ref_rd_q <= ref_mem[hist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cum_we) sc_mem[j_q] <= acc_s_d;
    sc_rd_q <= sc_mem[sc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cum_we) rc_mem[j_q] <= acc_r_d;
    rc_rd_q <= rc_mem[rc_ra];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    i_d         = i_q;
    j_d         = j_q;
    clr_addr_d  = clr_addr_q;
    clr_map_d   = clr_map_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    func_d      = func_q;
    lvl_d       = lvl_q;
    res_d       = res_q;
    kind_d      = kind_q;
    acc_s_d     = acc_s_q + CUMW'(src_rd_q);
    acc_r_d     = acc_r_q + CUMW'(ref_rd_q);
    s_d         = s_q;
    best_d      = best_q;
    win_d       = win_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d = in_data_i.func;
          ch_d   = '0;
          for (int c = 0; c < NCH; c++) begin
            lvl_d[c] = clamp_level(px_in[c]);
            if (inv_q && in_data_i.func != hmrgb_pkg::FUNC_LOAD_REF) begin
              lvl_d[c] = LVL_LAST - clamp_level(px_in[c]);
            end
          end
          case (in_data_i.func)
            hmrgb_pkg::FUNC_LOAD_SRC, hmrgb_pkg::FUNC_LOAD_REF: state_d = S_LD_RD;
            hmrgb_pkg::FUNC_MAP: state_d = S_MP_RD;
            hmrgb_pkg::FUNC_BUILD: begin
              j_d     = '0;
              acc_s_d = '0;
              acc_r_d = '0;
              state_d = S_PF_RD;
            end
            hmrgb_pkg::FUNC_CLEAR: begin
              sat_d      = 1'b0;
              clr_addr_d = '0;
              clr_map_d  = 1'b0;
              state_d    = S_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      S_CLR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == CLR_LAST) begin
          clr_map_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      S_LD_RD: state_d = S_LD_WR;
      S_LD_WR: begin
        if (hist_cur >= CNT_MAX) sat_d = 1'b1;
        if (ch_q == CH_LAST) begin
          state_d = S_IDLE;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_LD_RD;
        end
      end
      S_MP_RD: state_d = S_MP_WR;
      S_MP_WR: begin
        res_d[ch_q] = map_rd_q;
        if (ch_q == CH_LAST) begin
          kind_d  = hmrgb_pkg::KIND_PIXEL;
          state_d = S_PUSH;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_MP_RD;
        end
      end
      S_PF_RD: begin
        acc_s_d = acc_s_q;
        acc_r_d = acc_r_q;
        state_d = S_PF_AC;
      end
      S_PF_AC: begin
        if (j_q == LVL_LAST) begin
          i_d     = '0;
          state_d = S_SI_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_PF_RD;
        end
      end
      S_SI_RD: begin
        acc_s_d = acc_s_q;
        acc_r_d = acc_r_q;
        state_d = S_SI_LD;
      end
      S_SI_LD: begin
        acc_s_d = acc_s_q;
        acc_r_d = acc_r_q;
        s_d     = sc_rd_q;
        j_d     = '0;
        state_d = S_SJ_RD;
      end
      S_SJ_RD: begin
        acc_s_d = acc_s_q;
        acc_r_d = acc_r_q;
        state_d = S_SJ_CMP;
      end
      S_SJ_CMP: begin
        acc_s_d = acc_s_q;
        acc_r_d = acc_r_q;
        if (take) begin
          best_d = diff;
          win_d  = j_q;
        end
        if (j_q != LVL_LAST) begin
          j_d     = j_q + 1'b1;
          state_d = S_SJ_RD;
        end else if (i_q != LVL_LAST) begin
          i_d     = i_q + 1'b1;
          state_d = S_SI_RD;
        end else if (ch_q != CH_LAST) begin
          ch_d    = ch_q + 1'b1;
          j_d     = '0;
          acc_s_d = '0;
          acc_r_d = '0;
          state_d = S_PF_RD;
        end else begin
          kind_d  = hmrgb_pkg::KIND_BUILD;
          for (int c = 0; c < NCH; c++) res_d[c] = '0;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (can_push) begin
          out_valid_d           = 1'b1;
          out_d.result_kind     = kind_q;
          out_d.out_red         = 8'(res_q[0]);
          out_d.out_green       = '0;
          out_d.out_blue        = '0;
          if (NCH > 1) out_d.out_green = 8'(res_q[NCH > 1 ? 1 : 0]);
          if (NCH > 2) out_d.out_blue  = 8'(res_q[NCH > 2 ? 2 : 0]);
          out_d.count_saturated = sat_q;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ch_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      clr_addr_q  <= '0;
      clr_map_q   <= 1'b1;
      sat_q       <= 1'b0;
      inv_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      i_q         <= i_d;
      j_q         <= j_d;
      clr_addr_q  <= clr_addr_d;
      clr_map_q   <= clr_map_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) inv_q <= cfg_data_i;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    lvl_q   <= lvl_d;
    res_q   <= res_d;
    kind_q  <= kind_d;
    acc_s_q <= acc_s_d;
    acc_r_q <= acc_r_d;
    s_q     <= s_d;
    best_q  <= best_d;
    win_q   <= win_d;
    out_q   <= out_d;
  end

  // a push that finds room always shows a word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && can_push) |=> out_valid_q)
    else $error("push lost its word");

  // channel counter stays within the active channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q <= CH_LAST)
    else $error("channel counter out of range");

  // a stored count never exceeds the saturation limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LD_WR) |-> (hist_cur <= CNT_MAX))
    else $error("histogram count above limit");

endmodule
`default_nettype wire

// ===== sim/histogram_matching_rgb_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_matching_rgb_tb
// drives pixel loads, builds, maps and clears into the matching block, keeps
// its own histograms and mapping table, and checks every result word in order
// ----------------------------------------------------------------------------
module histogram_matching_rgb_tb;

  localparam int NCH    = 3;
  localparam int NLV    = 256;
  localparam int MAXCNT = 1048576;

  // holds the expected histograms, table and pending result words
  class match_scoreboard;
    int unsigned src_hist[NCH][NLV];
    int unsigned ref_hist[NCH][NLV];
    logic [7:0]  map_tbl[NCH][NLV];
    bit          sat_flag;
    bit          invert;
    hmrgb_pkg::out_word_t expected_words[$];
    int          errors;

    function new();
      foreach (src_hist[c, l]) begin
        src_hist[c][l] = 0;
        ref_hist[c][l] = 0;
        map_tbl[c][l]  = '0;
      end
      sat_flag = 1'b0;
      invert   = 1'b1;
      errors   = 0;
    endfunction

    function logic [7:0] prep(logic [7:0] v);
      return invert ? 8'(NLV - 1 - v) : v;
    endfunction

    function void bump(ref int unsigned cnt);
      if (cnt >= MAXCNT) begin
        cnt = MAXCNT;
        sat_flag = 1'b1;
      end else begin
        cnt++;
      end
    endfunction

    // nearest cumulative count per level, highest level on ties
    function void rebuild();
      longint s_cum[NLV];
      longint r_cum[NLV];
      longint s, r, best, d;
      int     win;
      for (int c = 0; c < NCH; c++) begin
        s = 0;
        r = 0;
        for (int i = 0; i < NLV; i++) begin
          s += src_hist[c][i];
          r += ref_hist[c][i];
          s_cum[i] = s;
          r_cum[i] = r;
        end
        for (int i = 0; i < NLV; i++) begin
          best = 0;
          win  = 0;
          for (int j = 0; j < NLV; j++) begin
            d = (r_cum[j] >= s_cum[i]) ? r_cum[j] - s_cum[i] : s_cum[i] - r_cum[j];
            if (j == 0 || d <= best) begin
              best = d;
              win  = j;
            end
          end
          map_tbl[c][i] = 8'(win);
        end
      end
    endfunction

    function void note_input(hmrgb_pkg::in_word_t w);
      hmrgb_pkg::out_word_t o;
      logic [7:0] px[NCH];
      px[0] = w.red;
      px[1] = w.green;
      px[2] = w.blue;
      o = '0;
      case (w.func)
        hmrgb_pkg::FUNC_LOAD_SRC:
          for (int c = 0; c < NCH; c++) bump(src_hist[c][prep(px[c])]);
        hmrgb_pkg::FUNC_LOAD_REF:
          for (int c = 0; c < NCH; c++) bump(ref_hist[c][px[c]]);
        hmrgb_pkg::FUNC_BUILD: begin
          rebuild();
          o.result_kind     = hmrgb_pkg::KIND_BUILD;
          o.count_saturated = sat_flag;
          expected_words.push_back(o);
        end
        hmrgb_pkg::FUNC_MAP: begin
          o.result_kind     = hmrgb_pkg::KIND_PIXEL;
          o.out_red         = map_tbl[0][prep(px[0])];
          o.out_green       = map_tbl[1][prep(px[1])];
          o.out_blue        = map_tbl[2][prep(px[2])];
          o.count_saturated = sat_flag;
          expected_words.push_back(o);
        end
        hmrgb_pkg::FUNC_CLEAR: begin
          foreach (src_hist[c, l]) begin
            src_hist[c][l] = 0;
            ref_hist[c][l] = 0;
          end
          sat_flag = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(hmrgb_pkg::out_word_t got);
      hmrgb_pkg::out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.result_kind !== exp_w.result_kind)
        $display("%0t: result_kind exp %0d got %0d", $time, exp_w.result_kind, got.result_kind);
      if (got.out_red !== exp_w.out_red)
        $display("%0t: out_red exp %0d got %0d", $time, exp_w.out_red, got.out_red);
      if (got.out_green !== exp_w.out_green)
        $display("%0t: out_green exp %0d got %0d", $time, exp_w.out_green, got.out_green);
      if (got.out_blue !== exp_w.out_blue)
        $display("%0t: out_blue exp %0d got %0d", $time, exp_w.out_blue, got.out_blue);
      if (got.count_saturated !== exp_w.count_saturated)
        $display("%0t: count_saturated exp %0d got %0d", $time, exp_w.count_saturated,
                 got.count_saturated);
      if (got !== exp_w) errors++;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  hmrgb_pkg::in_word_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  hmrgb_pkg::out_word_t out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i = 1'b0;

  // idle odds in percent for each side
  int tx_idle_pct = 6;
  int rx_idle_pct = 76;

  match_scoreboard sb = new();

  histogram_matching_rgb uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // receiver: take result words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // hard stop; the two builds dominate the run
  initial begin
    #50_000_000;
    $display("** histogram_matching_rgb: FAILED **");
    $finish;
  end

  // sender: optional idle gap, then hold the word until it is taken
  task automatic send_word(logic [2:0] f, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hmrgb_pkg::in_word_t w;
    w = '{func: f, red: r, green: g, blue: b};
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(w);
  endtask

  // wait for all results, then let a clear or load run out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  task automatic write_invert(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.invert = v;
  endtask

  // pixel values: uniform, a narrow band, or the extremes
  function automatic logic [7:0] pick_level();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(255));
      1:       return 8'($urandom_range(40, 90));
      default: return $urandom_range(1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  task automatic random_phase(int n_items, bit with_build);
    int sel;
    for (int k = 0; k < n_items; k++) begin
      if (with_build && k == n_items / 2) begin
        // pause until every result is back, then build from what was loaded
        drain();
        send_word(hmrgb_pkg::FUNC_BUILD, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      sel = $urandom_range(999);
      if (sel < 420)
        send_word(hmrgb_pkg::FUNC_LOAD_SRC, pick_level(), pick_level(), pick_level());
      else if (sel < 840)
        send_word(hmrgb_pkg::FUNC_LOAD_REF, pick_level(), pick_level(), pick_level());
      else if (sel < 975)
        send_word(hmrgb_pkg::FUNC_MAP, pick_level(), pick_level(), pick_level());
      else if (sel < 995)
        send_word(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_word(hmrgb_pkg::FUNC_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset-time invert, map before any build gives zeros
    send_word(hmrgb_pkg::FUNC_MAP, 8'd0, 8'd0, 8'd0);
    send_word(hmrgb_pkg::FUNC_MAP, 8'd255, 8'd255, 8'd255);
    // unused codes are dropped
    send_word(3'd5, 8'd255, 8'd0, 8'd255);
    send_word(3'd6, 8'd0, 8'd255, 8'd0);
    send_word(3'd7, 8'd255, 8'd255, 8'd255);
    // load extremes, clear them away, then load a small real set
    send_word(hmrgb_pkg::FUNC_LOAD_SRC, 8'd0, 8'd255, 8'd128);
    send_word(hmrgb_pkg::FUNC_LOAD_REF, 8'd255, 8'd0, 8'd127);
    send_word(hmrgb_pkg::FUNC_CLEAR, 8'd0, 8'd0, 8'd0);
    send_word(hmrgb_pkg::FUNC_LOAD_SRC, 8'd0, 8'd0, 8'd0);
    send_word(hmrgb_pkg::FUNC_LOAD_SRC, 8'd255, 8'd255, 8'd255);
    send_word(hmrgb_pkg::FUNC_LOAD_SRC, 8'd100, 8'd1, 8'd254);
    send_word(hmrgb_pkg::FUNC_LOAD_REF, 8'd0, 8'd255, 8'd7);
    send_word(hmrgb_pkg::FUNC_LOAD_REF, 8'd255, 8'd128, 8'd7);
    send_word(hmrgb_pkg::FUNC_LOAD_REF, 8'd17, 8'd0, 8'd200);
    send_word(hmrgb_pkg::FUNC_BUILD, 8'd0, 8'd0, 8'd0);
    send_word(hmrgb_pkg::FUNC_MAP, 8'd0, 8'd255, 8'd100);
    send_word(hmrgb_pkg::FUNC_MAP, 8'd255, 8'd0, 8'd1);
    send_word(hmrgb_pkg::FUNC_MAP, 8'd128, 8'd127, 8'd254);
    drain();
    write_invert(1'b0);
    send_word(hmrgb_pkg::FUNC_MAP, 8'd0, 8'd255, 8'd100);
    send_word(hmrgb_pkg::FUNC_MAP, 8'd255, 8'd0, 8'd1);
    send_word(hmrgb_pkg::FUNC_MAP, 8'd128, 8'd127, 8'd254);

    // random, receiver mostly stalled, no inversion
    random_phase(530, 1'b0);
    drain();
    write_invert(1'b1);
    // random, sender mostly idle, inversion back on, one build mid-way
    tx_idle_pct = 76;
    rx_idle_pct = 6;
    random_phase(530, 1'b1);
    drain();
    write_invert(1'b0);
    // random, both sides at full rate
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(530, 1'b0);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d result words never came", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("** histogram_matching_rgb: PASSED **");
    end else begin
      $display("** histogram_matching_rgb: FAILED **");
    end
    $finish;
  end

endmodule

// ===== histogram_matching_rgb.f =====
rtl/hmrgb_pkg.sv
rtl/histogram_matching_rgb.sv
sim/histogram_matching_rgb_tb.sv
